@@ rtl/hkle_pkg.sv @@
// Shared types, codes and key decode for the keyboard line editor.
package hkle_pkg;

  localparam logic [7:0] ShiftMask     = 8'h22;
  localparam logic [7:0] CodeBackspace = 8'h2A;
  localparam logic [7:0] CodeRight     = 8'h4F;
  localparam logic [7:0] CodeLeft      = 8'h50;
  localparam int unsigned QueueDepth   = 4;

  typedef enum logic [2:0] {
    EV_INSERTED = 3'd0,
    EV_DELETED  = 3'd1,
    EV_MOVED    = 3'd2,
    EV_DROPPED  = 3'd3,
    EV_READ     = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_LEFT   = 3'd3,
    ACT_RIGHT  = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_LEFT   = 3'd2,
    OP_RIGHT  = 3'd3,
    OP_READ   = 3'd4,
    OP_END    = 3'd5
  } op_e;

  typedef struct packed {
    op_e        kind;
    logic [6:0] ch;
    logic [9:0] idx;
  } op_t;

  typedef struct packed {
    act_e       act;
    logic [6:0] ch;
  } dec_t;

  typedef struct packed {
    event_e      kind;
    logic [6:0]  ch;
    logic [10:0] cur;
    logic [10:0] len;
    logic        last;
  } res_t;

  // US layout usage code to action and character
  function automatic dec_t hkle_decode(input logic [7:0] code, input logic shift);
    dec_t d;
    logic [7:0] off;
    d.act = ACT_NONE;
    d.ch  = 7'd0;
    off   = 8'd0;
    if (code >= 8'h04 && code <= 8'h1D) begin
      off   = code - 8'h04;
      d.act = ACT_INSERT;
      d.ch  = shift ? (7'h41 + off[6:0]) : (7'h61 + off[6:0]);
    end else if (code >= 8'h1E && code <= 8'h27) begin
      off   = code - 8'h1E;
      d.act = ACT_INSERT;
      if (!shift) begin
        d.ch = (off == 8'd9) ? 7'h30 : (7'h31 + off[6:0]);
      end else begin
        case (off[3:0])
          4'd0:    d.ch = 7'h21;
          4'd1:    d.ch = 7'h40;
          4'd2:    d.ch = 7'h23;
          4'd3:    d.ch = 7'h24;
          4'd4:    d.ch = 7'h25;
          4'd5:    d.ch = 7'h5E;
          4'd6:    d.ch = 7'h26;
          4'd7:    d.ch = 7'h2A;
          4'd8:    d.ch = 7'h28;
          default: d.ch = 7'h29;
        endcase
      end
    end else if (code == 8'h28) begin
      d.act = ACT_INSERT;
      d.ch  = 7'h0A;
    end else if (code == 8'h2C) begin
      d.act = ACT_INSERT;
      d.ch  = 7'h20;
    end else if (code >= 8'h2D && code <= 8'h38 && code != 8'h32) begin
      d.act = ACT_INSERT;
      case (code)
        8'h2D:   d.ch = shift ? 7'h5F : 7'h2D;
        8'h2E:   d.ch = shift ? 7'h2B : 7'h3D;
        8'h2F:   d.ch = shift ? 7'h7B : 7'h5B;
        8'h30:   d.ch = shift ? 7'h7D : 7'h5D;
        8'h31:   d.ch = shift ? 7'h7C : 7'h5C;
        8'h33:   d.ch = shift ? 7'h3A : 7'h3B;
        8'h34:   d.ch = shift ? 7'h22 : 7'h27;
        8'h35:   d.ch = shift ? 7'h7E : 7'h60;
        8'h36:   d.ch = shift ? 7'h3C : 7'h2C;
        8'h37:   d.ch = shift ? 7'h3E : 7'h2E;
        default: d.ch = shift ? 7'h3F : 7'h2F;
      endcase
    end else if (code == CodeBackspace) begin
      d.act = ACT_DELETE;
    end else if (code == CodeLeft) begin
      d.act = ACT_LEFT;
    end else if (code == CodeRight) begin
      d.act = ACT_RIGHT;
    end
    return d;
  endfunction

endpackage

@@ rtl/hkle_if.sv @@
// Valid/ready channel interfaces for keyboard items and editor results.
interface hkle_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] modifiers;
  logic [7:0] key_slot0;
  logic [7:0] key_slot1;
  logic [7:0] key_slot2;
  logic [7:0] key_slot3;
  logic [7:0] key_slot4;
  logic [7:0] key_slot5;
  logic [9:0] read_index;
  modport source (output valid, action, modifiers, key_slot0, key_slot1, key_slot2,
                  key_slot3, key_slot4, key_slot5, read_index, input ready);
  modport sink   (input valid, action, modifiers, key_slot0, key_slot1, key_slot2,
                  key_slot3, key_slot4, key_slot5, read_index, output ready);
endinterface

interface hkle_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [6:0]  char_code;
  logic [10:0] cursor_pos;
  logic [10:0] text_length;
  logic        last;
  modport source (output valid, event_kind, char_code, cursor_pos, text_length, last,
                  input ready);
  modport sink   (input valid, event_kind, char_code, cursor_pos, text_length, last,
                  output ready);
endinterface

@@ rtl/hkle_front.sv @@
// Front end: takes items, finds new presses slot by slot, queues ops.
module hkle_front #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hkle_in_if.sink       in_i,
  output logic          push_o,
  output hkle_pkg::op_t push_op_o,
  input  logic          full_i
);
  import hkle_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_READ = 4'b0010,
    F_SLOT = 4'b0100,
    F_END  = 4'b1000
  } fstate_e;

  fstate_e    state_q, state_d;
  logic [7:0] keys_q [6];
  logic       shift_q;
  logic [9:0] idx_q;
  logic [2:0] slot_q, slot_d;
  logic [5:0] held_q, held_d;
  logic [7:0] code;
  dec_t       dec;
  logic       adv;
  logic       accept;

  assign in_i.ready = (state_q == F_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign code       = keys_q[slot_q];
  assign dec        = hkle_decode(code, shift_q);

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    held_d    = held_q;
    push_o    = 1'b0;
    push_op_o = '{kind: OP_END, ch: 7'd0, idx: idx_q};
    adv       = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          slot_d  = 3'd0;
          state_d = in_i.action ? F_READ : F_SLOT;
        end
      end
      F_READ: begin
        push_op_o.kind = OP_READ;
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_END;
        end
      end
      F_SLOT: begin
        if (code == 8'd0) begin
          held_d[slot_q] = 1'b0;
          adv            = 1'b1;
        end else if (held_q[slot_q]) begin
          adv = 1'b1;
        end else if (dec.act == ACT_NONE) begin
          held_d[slot_q] = 1'b1;
          adv            = 1'b1;
        end else if (!full_i) begin
          held_d[slot_q] = 1'b1;
          adv            = 1'b1;
          push_o         = 1'b1;
          push_op_o.ch   = dec.ch;
          case (dec.act)
            ACT_INSERT: push_op_o.kind = OP_INSERT;
            ACT_DELETE: push_op_o.kind = OP_DELETE;
            ACT_LEFT:   push_op_o.kind = OP_LEFT;
            default:    push_op_o.kind = OP_RIGHT;
          endcase
        end
        if (adv) begin
          if (slot_q == 3'(KEY_SLOTS - 1)) state_d = F_END;
          else slot_d = slot_q + 3'd1;
        end
      end
      F_END: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      slot_q  <= 3'd0;
      held_q  <= 6'd0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      keys_q[0] <= in_i.key_slot0;
      keys_q[1] <= in_i.key_slot1;
      keys_q[2] <= in_i.key_slot2;
      keys_q[3] <= in_i.key_slot3;
      keys_q[4] <= in_i.key_slot4;
      keys_q[5] <= in_i.key_slot5;
      shift_q   <= |(in_i.modifiers & ShiftMask);
      idx_q     <= in_i.read_index;
    end
  end

endmodule

@@ rtl/hkle_queue.sv @@
// Short op queue between front and back.
module hkle_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hkle_pkg::op_t push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output hkle_pkg::op_t pop_op_o,
  output logic          empty_o
);
  import hkle_pkg::*;

  localparam int unsigned PW = $clog2(QueueDepth);

  op_t           mem_q [QueueDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign full_o   = (cnt_q == (PW+1)'(QueueDepth));
  assign empty_o  = (cnt_q == '0);
  assign pop_op_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_op_i;
  end

endmodule

@@ rtl/hkle_back.sv @@
// Back end: text store, cursor and length, shift passes and result register.
module hkle_back #(
  parameter int unsigned BUF_DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  hkle_pkg::op_t op_i,
  output logic          pop_o,
  hkle_out_if.source    out_o
);
  import hkle_pkg::*;

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);
  localparam int unsigned XW = (CW > 10) ? CW : 10;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_INS  = 4'b0010,
    B_DEL  = 4'b0100,
    B_RD   = 4'b1000
  } bstate_e;

  bstate_e       state_q, state_d;
  logic [CW-1:0] cur_q, cur_d, len_q, len_d, p_q, p_d;
  logic [AW-1:0] wa_q, wa_d;
  logic          wv_q, wv_d, first_q, first_d, hit_q, hit_d;
  logic [6:0]    ch_q, ch_d, gone_q, gone_d;
  res_t          pend_q, pend_d, out_q, out_d;
  logic          pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic          res_v, flush;
  event_e        res_kind;
  logic [6:0]    res_ch;
  res_t          res;

  logic [6:0]    text_store [BUF_DEPTH];
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [6:0]    wd, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) text_store[wa] <= wd;
    if (re) rdata_q <= text_store[ra];
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    len_d    = len_q;
    p_d      = p_q;
    wa_d     = wa_q;
    wv_d     = wv_q;
    first_d  = first_q;
    hit_d    = hit_q;
    ch_d     = ch_q;
    gone_d   = gone_q;
    pop_o    = 1'b0;
    res_v    = 1'b0;
    flush    = 1'b0;
    res_kind = EV_READ;
    res_ch   = 7'd0;
    we       = 1'b0;
    wa       = wa_q;
    wd       = rdata_q;
    re       = 1'b0;
    ra       = AW'(op_i.idx);
    case (state_q)
      B_IDLE: begin
        if (!empty_i && !out_v_q) begin
          pop_o = 1'b1;
          case (op_i.kind)
            OP_INSERT: begin
              if (len_q == CW'(BUF_DEPTH)) begin
                res_v    = 1'b1;
                res_kind = EV_DROPPED;
              end else begin
                p_d     = len_q;
                wv_d    = 1'b0;
                ch_d    = op_i.ch;
                state_d = B_INS;
              end
            end
            OP_DELETE: begin
              if (cur_q != '0) begin
                p_d     = cur_q - 1'b1;
                wv_d    = 1'b0;
                state_d = B_DEL;
              end
            end
            OP_LEFT: begin
              if (cur_q != '0) begin
                cur_d    = cur_q - 1'b1;
                res_v    = 1'b1;
                res_kind = EV_MOVED;
              end
            end
            OP_RIGHT: begin
              if (cur_q < len_q) begin
                cur_d    = cur_q + 1'b1;
                res_v    = 1'b1;
                res_kind = EV_MOVED;
              end
            end
            OP_READ: begin
              hit_d   = XW'(op_i.idx) < XW'(len_q);
              re      = 1'b1;
              state_d = B_RD;
            end
            default: flush = 1'b1;
          endcase
        end
      end
      B_RD: begin
        res_v    = 1'b1;
        res_kind = EV_READ;
        res_ch   = hit_q ? rdata_q : 7'd0;
        state_d  = B_IDLE;
      end
      B_INS: begin
        // tail moves up one place, top end first
        if (wv_q) we = 1'b1;
        if (p_q > cur_q) begin
          re   = 1'b1;
          ra   = AW'(p_q - 1'b1);
          wa_d = AW'(p_q);
          wv_d = 1'b1;
          p_d  = p_q - 1'b1;
        end else begin
          wv_d = 1'b0;
          if (!wv_q) begin
            we       = 1'b1;
            wa       = AW'(cur_q);
            wd       = ch_q;
            cur_d    = cur_q + 1'b1;
            len_d    = len_q + 1'b1;
            res_v    = 1'b1;
            res_kind = EV_INSERTED;
            res_ch   = ch_q;
            state_d  = B_IDLE;
          end
        end
      end
      B_DEL: begin
        // first read fetches the deleted char, the rest move down one place
        if (wv_q) begin
          if (first_q) gone_d = rdata_q;
          else we = 1'b1;
        end
        if (p_q < len_q) begin
          re      = 1'b1;
          ra      = AW'(p_q);
          wa_d    = AW'(p_q - 1'b1);
          first_d = (p_q == cur_q - 1'b1);
          wv_d    = 1'b1;
          p_d     = p_q + 1'b1;
        end else begin
          wv_d = 1'b0;
          if (!wv_q) begin
            cur_d    = cur_q - 1'b1;
            len_d    = len_q - 1'b1;
            res_v    = 1'b1;
            res_kind = EV_DELETED;
            res_ch   = gone_q;
            state_d  = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase

    res = '{kind: res_kind, ch: res_ch, cur: 11'(cur_d), len: 11'(len_d), last: 1'b0};

    // one result is held back until the next one or the end marker shows up
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !out_o.ready;
    if (flush && pend_v_q) begin
      out_d      = pend_q;
      out_d.last = 1'b1;
      out_v_d    = 1'b1;
      pend_v_d   = 1'b0;
    end
    if (res_v) begin
      if (pend_v_q) begin
        out_d   = pend_q;
        out_v_d = 1'b1;
      end
      pend_d   = res;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      cur_q    <= '0;
      len_q    <= '0;
      wv_q     <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      len_q    <= len_d;
      wv_q     <= wv_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    wa_q    <= wa_d;
    first_q <= first_d;
    hit_q   <= hit_d;
    ch_q    <= ch_d;
    gone_q  <= gone_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign out_o.valid       = out_v_q;
  assign out_o.event_kind  = out_q.kind;
  assign out_o.char_code   = out_q.ch;
  assign out_o.cursor_pos  = out_q.cur;
  assign out_o.text_length = out_q.len;
  assign out_o.last        = out_q.last;

endmodule

@@ rtl/hid_keyboard_line_editor_core.sv @@
// Top level of the HID keyboard line editor: front end, op queue, back end.
//
//  channel | dir | handshake      | payload
//  in_i    | in  | valid / ready  | action, modifiers, key_slot0..5, read_index
//  out_o   | out | valid / ready  | event_kind, char_code, cursor_pos, text_length, last
//
// A report walks one slot per cycle in the front, waiting on a new press while the
// op queue is full; each new press of a known key becomes an op. Insert/delete
// shift the tail through the text store (one read and one write port) at one char
// a cycle; cursor moves and reads do no shift.
// Reset clears cursor, length, held slots and control; the text store is not cleared.
// A result is held back until the next result or the end marker so its last flag
// is known; out stalls hold the back end, and the front stalls in turn once the op
// queue is full.
module hid_keyboard_line_editor_core #(
  parameter int unsigned BUF_DEPTH = 1024,
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hkle_in_if.sink     in_i,
  hkle_out_if.source  out_o
);
  import hkle_pkg::*;

  logic push, full, pop, empty;
  op_t  push_op, pop_op;

  hkle_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .push_o    (push),
    .push_op_o (push_op),
    .full_i    (full)
  );

  hkle_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .pop_op_o  (pop_op),
    .empty_o   (empty)
  );

  hkle_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .op_i    (pop_op),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ rtl/hkle_checker.sv @@
// Port-level checks for the line editor, bound to the top level.
module hkle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  event_kind_i,
  input logic [6:0]  char_code_i,
  input logic [10:0] cursor_pos_i,
  input logic [10:0] text_length_i
);
  import hkle_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (event_kind_i <= EV_READ))
    else $error("bad event kind");

  a_insert_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i == EV_INSERTED |-> cursor_pos_i != 11'd0 && text_length_i != 11'd0)
    else $error("insert left cursor or length at zero");

  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == EV_MOVED || event_kind_i == EV_DROPPED)
      |-> char_code_i == 7'd0)
    else $error("char on move or drop");
endmodule

bind hid_keyboard_line_editor_core hkle_checker u_hkle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .event_kind_i  (out_o.event_kind),
  .char_code_i   (out_o.char_code),
  .cursor_pos_i  (out_o.cursor_pos),
  .text_length_i (out_o.text_length)
);
